### hdl/esc_pkg.sv
// escape string encoder: shared package
// widths, payload beat structs and the internal sequence and load structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int TOTAL_W     = 16;
	localparam int CAP_W       = 16;
	localparam int SUM_W       = ((LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W) + 1;
	localparam int SEQ_MAX     = 4;
	localparam int CNT_W       = $clog2(SEQ_MAX);

	typedef struct packed {
		logic [7:0] src_byte;
		logic       end_of_string;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               byte_valid;
		logic               run_last;
		logic               done_res;
		logic [TOTAL_W-1:0] total_length;
	} out_beat_t;

	// escaped form of one source byte, first byte in slot 0
	typedef struct packed {
		logic [SEQ_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt_m1;
	} seq_t;

	// one sequence handed to the output stage
	typedef struct packed {
		logic [SEQ_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt_m1;
		logic                    byte_valid;
		logic                    done_res;
		logic [TOTAL_W-1:0]      first_len;
	} emit_load_t;

endpackage

`default_nettype wire

### hdl/esc_encode.sv
// escape string encoder: byte classifier and escape sequence builder
// purely combinational; uses esc_pkg
`timescale 1ns / 1ps
`default_nettype none

module esc_encode (
	input  wire logic [7:0]    src_byte,
	output esc_pkg::seq_t      seq
);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [15:0][7:0] HEX_DIGITS = {
		8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
		8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
	};

	logic [7:0] letter;

	always_comb begin
		case (src_byte)
			CH_BEL:    letter = 8'h61;
			CH_BS:     letter = 8'h62;
			CH_TAB:    letter = 8'h74;
			CH_LF:     letter = 8'h6E;
			CH_VT:     letter = 8'h76;
			CH_FF:     letter = 8'h66;
			CH_CR:     letter = 8'h72;
			CH_BSLASH: letter = CH_BSLASH;
			CH_QUOTE:  letter = CH_QUOTE;
			default:   letter = 8'h00;
		endcase
	end

	always_comb begin
		seq.bytes = '0;
		if (letter != 8'h00) begin
			seq.bytes[0] = CH_BSLASH;
			seq.bytes[1] = letter;
			seq.cnt_m1   = esc_pkg::CNT_W'(1);
		end else if (src_byte inside {[CH_SPACE:CH_TILDE]}) begin
			seq.bytes[0] = src_byte;
			seq.cnt_m1   = esc_pkg::CNT_W'(0);
		end else begin
			seq.bytes[0] = CH_BSLASH;
			seq.bytes[1] = CH_X;
			seq.bytes[2] = HEX_DIGITS[src_byte[7:4]];
			seq.bytes[3] = HEX_DIGITS[src_byte[3:0]];
			seq.cnt_m1   = esc_pkg::CNT_W'(3);
		end
	end

endmodule

`default_nettype wire

### hdl/esc_emit.sv
// escape string encoder: output stage, sends one loaded sequence a beat per cycle
// holds the result register and stalls while dst_ready is low; uses esc_pkg
`timescale 1ns / 1ps
`default_nettype none

module esc_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire esc_pkg::emit_load_t load_data,
	output logic                     free,
	output logic                     dst_valid,
	input  wire logic                dst_ready,
	output esc_pkg::out_beat_t       dst_data
);

	logic                                 busy_q;
	logic [esc_pkg::SEQ_MAX-1:0][7:0]     bytes_q;
	logic [esc_pkg::CNT_W-1:0]            rem_q;
	logic                                 valid_q;
	logic                                 done_q;
	logic [esc_pkg::TOTAL_W-1:0]          len_q;
	logic                                 beat_done;
	logic                                 last;

	assign last      = (rem_q == '0);
	assign beat_done = busy_q & dst_ready;
	assign free      = !busy_q | (beat_done & last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			rem_q  <= load_data.cnt_m1;
		end else if (beat_done) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				rem_q <= rem_q - esc_pkg::CNT_W'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= load_data.bytes;
			valid_q <= load_data.byte_valid;
			done_q  <= load_data.done_res;
			len_q   <= load_data.first_len;
		end else if (beat_done && !last) begin
			bytes_q <= {8'h00, bytes_q[esc_pkg::SEQ_MAX-1:1]};
			len_q   <= len_q + esc_pkg::TOTAL_W'(1);
		end
	end

	assign dst_valid             = busy_q;
	assign dst_data.out_byte     = bytes_q[0];
	assign dst_data.byte_valid   = valid_q;
	assign dst_data.run_last     = last;
	assign dst_data.done_res     = done_q;
	assign dst_data.total_length = len_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && done_q |-> rem_q == '0)
		else $error("terminator result spans more than one beat");

	a_invalid_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !valid_q |-> done_q)
		else $error("invalid byte outside terminator result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("sequence loaded over one still being sent");

	a_stay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		beat_done && !last |=> busy_q && len_q == $past(len_q) + esc_pkg::TOTAL_W'(1))
		else $error("sequence cut short or length not advanced");

endmodule

`default_nettype wire

### hdl/escape_string_encoder.sv
// escape string encoder: top level with input register, length state and capacity
// uses esc_pkg, esc_encode and esc_emit
//
// src channel: one source byte per beat, or a terminator beat (end_of_string = 1).
// dst channel: one escaped byte per beat; run_last marks the final byte of the
//   sequence for one source byte, done_res marks the NUL that answers a terminator.
// cfg_we / cfg_wdata write the destination capacity (bytes, closing NUL included);
//   write it only while no beat is in flight.
// A source beat is registered in the input register, then loaded into the output
//   stage register, before its first result beat appears on dst.
// The dst channel moves one beat per cycle while dst_ready is high; a byte gives as
//   many beats as its escaped form is long: 1 for printable, 2 for a letter escape,
//   4 for a hex escape; a terminator gives 1, a refused byte none.
// The input register takes the next source beat while the output stage is still
//   sending, so a stalled dst channel holds back src only once both are full.
// Once a sequence would leave no room for the NUL, that byte and later bytes give nothing until
//   the terminator, which reports the length reached and rearms the block.
// Reset clears the capacity to zero, the length count and the stop flag, and
//   empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module escape_string_encoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [15:0]         cfg_wdata,
	input  wire logic                src_valid,
	output logic                     src_ready,
	input  wire esc_pkg::in_beat_t   src_data,
	output logic                     dst_valid,
	input  wire logic                dst_ready,
	output esc_pkg::out_beat_t       dst_data
);

	logic                               valid_s1;
	esc_pkg::in_beat_t                  item_s1;
	logic [esc_pkg::CAP_W-1:0]          cap_q;
	logic [esc_pkg::LENGTH_BITS-1:0]    count_q;
	logic                               full_stop_q;

	esc_pkg::seq_t                      seq;
	esc_pkg::emit_load_t                load_data;
	logic                               term;
	logic                               cap_zero;
	logic [esc_pkg::SUM_W-1:0]          sum;
	logic                               no_room;
	logic                               drop;
	logic                               emits;
	logic                               emit_free;
	logic                               consume_s1;
	logic                               emit_load;

	esc_encode u_encode (
		.src_byte (item_s1.src_byte),
		.seq      (seq)
	);

	assign term     = item_s1.end_of_string;
	assign cap_zero = (cap_q == '0);
	assign sum      = esc_pkg::SUM_W'(count_q) + esc_pkg::SUM_W'(seq.cnt_m1)
	                  + esc_pkg::SUM_W'(1);
	assign no_room  = (sum >= esc_pkg::SUM_W'(cap_q))
	                  || ((sum >> esc_pkg::LENGTH_BITS) != '0);
	assign drop     = full_stop_q | cap_zero | no_room;
	assign emits    = term | !drop;

	assign consume_s1 = valid_s1 & (!emits | emit_free);
	assign emit_load  = consume_s1 & emits;
	assign src_ready  = !valid_s1 | consume_s1;

	always_comb begin
		if (term) begin
			load_data.bytes      = '0;
			load_data.cnt_m1     = '0;
			load_data.byte_valid = !cap_zero;
			load_data.done_res   = 1'b1;
			load_data.first_len  = cap_zero ? '0 : esc_pkg::TOTAL_W'(count_q);
		end else begin
			load_data.bytes      = seq.bytes;
			load_data.cnt_m1     = seq.cnt_m1;
			load_data.byte_valid = 1'b1;
			load_data.done_res   = 1'b0;
			load_data.first_len  = esc_pkg::TOTAL_W'(count_q) + esc_pkg::TOTAL_W'(1);
		end
	end

	esc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit_load),
		.load_data (load_data),
		.free      (emit_free),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready) begin
			item_s1 <= src_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			full_stop_q <= 1'b0;
		end else if (consume_s1) begin
			if (term) begin
				count_q     <= '0;
				full_stop_q <= 1'b0;
			end else if (!full_stop_q && !cap_zero) begin
				if (no_room) begin
					full_stop_q <= 1'b1;
				end else begin
					count_q <= esc_pkg::LENGTH_BITS'(sum);
				end
			end
		end
	end

	a_term_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		consume_s1 && term |=> count_q == '0 && !full_stop_q)
		else $error("terminator did not rearm the encoder");

	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !term && full_stop_q |-> !emit_load)
		else $error("byte sent after stop");

	a_count_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load && !term |-> sum < esc_pkg::SUM_W'(cap_q))
		else $error("sequence would leave no room for the closing byte");

endmodule

`default_nettype wire

### dv/tb.sv
// testbench for escape_string_encoder: directed and random strings, checked beat by beat
// depends on esc_pkg and escape_string_encoder from hdl
`timescale 1ns / 1ps
`default_nettype none

module tb;

	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_UPA   = "A";
	localparam logic [7:0] CH_X     = "x";
	localparam logic [15:0] COUNT_TOP = 16'hFFFF;
	localparam int LONG_HOLD = 120;
	localparam int SETTLE    = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic      src_valid = 1'b0;
	logic      src_ready;
	esc_pkg::in_beat_t  src_data = '0;
	logic      dst_valid;
	logic      dst_ready = 1'b0;
	esc_pkg::out_beat_t dst_data;

	escape_string_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	// model state
	logic [15:0] capacity = '0;
	logic [15:0] written_len = '0;
	logic        stopped = 1'b0;

	esc_pkg::in_beat_t  src_pending[$];
	esc_pkg::out_beat_t escaped_q[$];

	int  errors = 0;
	int  accepted_items = 0;
	bit  idle_en = 1'b1;
	bit  src_busy = 1'b0;
	int  src_acc_cnt = 0;
	int  src_acc_seen = 0;
	int  src_gap = 0;
	int  dst_stall = 0;
	int  hold_left = 0;
	int  long_hold_req = 0;
	int  long_hold_seen = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_en || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// escaped form of one beat, pushed as expected output beats
	task automatic escape_src_beat(input esc_pkg::in_beat_t b);
		logic [7:0]  seq [4];
		logic [7:0]  letter;
		logic [16:0] sum;
		esc_pkg::out_beat_t r;
		int          n;
		accepted_items++;
		if (b.end_of_string) begin
			r.out_byte     = CH_NUL;
			r.byte_valid   = (capacity != 0);
			r.run_last     = 1'b1;
			r.done_res     = 1'b1;
			r.total_length = (capacity == 0) ? '0 : written_len;
			escaped_q.push_back(r);
			written_len = '0;
			stopped = 1'b0;
			return;
		end
		if (stopped || capacity == 0)
			return;
		case (b.src_byte)
			CH_BEL:  letter = "a";
			CH_BS:   letter = "b";
			CH_TAB:  letter = "t";
			CH_LF:   letter = "n";
			CH_VT:   letter = "v";
			CH_FF:   letter = "f";
			CH_CR:   letter = "r";
			CH_BSL:  letter = CH_BSL;
			CH_DQ:   letter = CH_DQ;
			default: letter = CH_NUL;
		endcase
		if (letter != CH_NUL) begin
			seq[0] = CH_BSL;
			seq[1] = letter;
			n = 2;
		end else if (b.src_byte >= PRINT_LO && b.src_byte <= PRINT_HI) begin
			seq[0] = b.src_byte;
			n = 1;
		end else begin
			seq[0] = CH_BSL;
			seq[1] = CH_X;
			seq[2] = (b.src_byte[7:4] < 4'd10) ? CH_ZERO + 8'(b.src_byte[7:4])
				: CH_UPA + 8'(b.src_byte[7:4]) - 8'd10;
			seq[3] = (b.src_byte[3:0] < 4'd10) ? CH_ZERO + 8'(b.src_byte[3:0])
				: CH_UPA + 8'(b.src_byte[3:0]) - 8'd10;
			n = 4;
		end
		sum = 17'(written_len) + 17'(n);
		if (sum >= 17'(capacity) || sum > 17'(COUNT_TOP)) begin
			stopped = 1'b1;
			return;
		end
		for (int i = 0; i < n; i++) begin
			written_len = written_len + 1'b1;
			r.out_byte     = seq[i];
			r.byte_valid   = 1'b1;
			r.run_last     = (i == n - 1);
			r.done_res     = 1'b0;
			r.total_length = written_len;
			escaped_q.push_back(r);
		end
	endtask

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// sender
	always @(negedge clk) begin
		if (src_acc_cnt != src_acc_seen) begin
			src_acc_seen = src_acc_cnt;
			src_busy = 1'b0;
			src_gap = pick_gap();
		end
		if (!src_busy && arst_n) begin
			if (src_gap > 0)
				src_gap--;
			else if (src_pending.size() != 0) begin
				src_data <= src_pending.pop_front();
				src_busy = 1'b1;
			end
		end
		src_valid <= src_busy;
	end

	// receiver
	always @(negedge clk) begin
		if (long_hold_req != long_hold_seen) begin
			long_hold_seen = long_hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			dst_ready <= 1'b0;
		end else if (dst_stall > 0) begin
			dst_stall--;
			dst_ready <= 1'b0;
		end else begin
			dst_ready <= 1'b1;
			dst_stall = pick_gap();
		end
	end

	// beat monitor
	always @(posedge clk) begin
		esc_pkg::out_beat_t e;
		if (arst_n) begin
			if (src_valid && src_ready) begin
				src_acc_cnt++;
				escape_src_beat(src_data);
			end
			if (dst_valid && dst_ready) begin
				if (escaped_q.size() == 0) begin
					$display("%0t: unexpected dst beat, expected none, actual %p", $time, dst_data);
					errors++;
				end else begin
					e = escaped_q.pop_front();
					check_field("out_byte", int'(e.out_byte), int'(dst_data.out_byte));
					check_field("byte_valid", int'(e.byte_valid), int'(dst_data.byte_valid));
					check_field("run_last", int'(e.run_last), int'(dst_data.run_last));
					check_field("done_res", int'(e.done_res), int'(dst_data.done_res));
					check_field("total_length", int'(e.total_length),
						int'(dst_data.total_length));
				end
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		esc_pkg::in_beat_t t;
		t.src_byte = b;
		t.end_of_string = 1'b0;
		src_pending.push_back(t);
	endtask

	task automatic push_term();
		esc_pkg::in_beat_t t;
		t.src_byte = 8'($urandom_range(0, 255));
		t.end_of_string = 1'b1;
		src_pending.push_back(t);
	endtask

	task automatic wait_drained();
		while (src_pending.size() != 0 || src_busy || escaped_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		capacity = v;
	endtask

	function automatic logic [7:0] rand_src_byte();
		logic [7:0] esc_set [9];
		int r;
		esc_set = '{CH_BEL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_BSL, CH_DQ};
		r = $urandom_range(0, 9);
		if (r < 5)
			return 8'($urandom_range(PRINT_LO, PRINT_HI));
		if (r < 7)
			return esc_set[$urandom_range(0, 8)];
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [15:0] cap_pick;
		int nstr;
		int len;
		int ph;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every escape class and the byte extremes
		write_capacity(16'd64);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_BEL);
		push_byte(CH_BS);
		push_byte(CH_TAB);
		push_byte(CH_LF);
		push_byte(CH_VT);
		push_byte(CH_FF);
		push_byte(CH_CR);
		push_byte(CH_BSL);
		push_byte(CH_DQ);
		push_byte(PRINT_LO);
		push_byte(PRINT_HI);
		push_byte(8'h7F);
		push_byte(8'h80);
		push_term();
		wait_drained();

		// zero capacity
		write_capacity(16'd0);
		push_byte("A");
		push_byte(8'h01);
		push_term();
		wait_drained();

		// no room, capacity lowered mid-string, terminator while stopped
		write_capacity(16'd12);
		push_byte("A");
		push_byte("B");
		push_byte(8'h01);
		wait_drained();
		write_capacity(16'd8);
		push_byte(CH_TAB);
		push_byte("C");
		push_term();
		wait_drained();

		// random strings over a range of capacities
		ph = 0;
		while (accepted_items < 180 && ph < 80) begin
			case (ph)
				0: cap_pick = 16'hFFFF;
				1: cap_pick = 16'd1;
				2: cap_pick = 16'd0;
				default: begin
					case ($urandom_range(0, 9))
						0: cap_pick = 16'd0;
						1: cap_pick = 16'd1;
						2: cap_pick = 16'hFFFF;
						3: cap_pick = 16'($urandom_range(2, 65534));
						default: cap_pick = 16'($urandom_range(2, 30));
					endcase
				end
			endcase
			write_capacity(cap_pick);
			idle_en = (ph != 0) && ($urandom_range(0, 4) != 0);
			nstr = (ph == 0) ? 4 : $urandom_range(2, 5);
			for (int s = 0; s < nstr; s++) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
				for (int k = 0; k < len; k++)
					push_byte(rand_src_byte());
				// leave the last string open now and then so it spans a capacity change
				if (s != nstr - 1 || $urandom_range(0, 2) != 0)
					push_term();
			end
			if (ph == 0) begin
				@(posedge clk);
				long_hold_req++;
			end
			wait_drained();
			ph++;
		end
		push_term();
		wait_drained();

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hdl/esc_pkg.sv
hdl/esc_encode.sv
hdl/esc_emit.sv
hdl/escape_string_encoder.sv
dv/tb.sv
